[hdl/fpa_pkg.sv]
package fpa_pkg;

  // Q format fraction width
  localparam int unsigned FRAC_BITS = 16;

  // one restoring-division step per stage over the (64 + FRAC_BITS)-bit dividend
  localparam int unsigned STEPS    = 64 + FRAC_BITS;
  // remainder of the integer dividend is complete after this step
  localparam int unsigned MOD_STEP = 64;
  // stage at which the finished product joins the main pipe
  localparam int unsigned MUL_STEP = 2;

  // operation codes
  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_SUB      = 3'd1;
  localparam logic [2:0] OP_MUL      = 3'd2;
  localparam logic [2:0] OP_DIV      = 3'd3;
  localparam logic [2:0] OP_MOD      = 3'd4;
  localparam logic [2:0] OP_NEG      = 3'd5;
  localparam logic [2:0] OP_FROM_INT = 3'd6;
  localparam logic [2:0] OP_UNUSED   = 3'd7;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } in_t;

  typedef struct packed {
    logic signed [63:0] result;
    logic               divide_by_zero;
  } out_t;

endpackage

[hdl/fixed_point_alu_core.sv]
// Signed 64-bit fixed-point ALU, Q format with fpa_pkg::FRAC_BITS fraction bits.
// Input channel: in_valid_i / in_stall_o with payload in_data_i (op, a, b).
// Output channel: out_valid_o / out_stall_i with payload out_data_o
// (result, divide_by_zero). A transaction completes at a rising edge where
// valid is high and stall is low.
// Every op yields exactly one result, in order of acceptance.
// From the accepting edge, each op passes the entry stage, the divider
// stages and the output register, the same path for every op. The
// depth is set by the pipelined restoring divider, one quotient bit per stage.
// Multiply uses four 32x32 partial products over three stages in parallel.
// Throughput: one transaction per cycle while the output is not stalled.
// When the output is stalled with a result waiting, the whole pipe holds and
// in_stall_o rises in the same cycle; nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits; the pipe comes
// out of reset empty and ready.
// Div and mod with b == 0 give result 0 and divide_by_zero 1. Op 7 gives 0.
module fixed_point_alu_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  fpa_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fpa_pkg::out_t  out_data_o
);

  typedef struct packed {
    logic        valid;
    logic [2:0]  op;
    logic [63:0] n;     // remaining dividend bits, msb first
    logic [63:0] d;     // divisor magnitude
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] modr;
    logic [63:0] res;   // result of the non-divide ops
    logic        neg_q;
    logic        neg_r;
    logic        dz;
  } stg_t;

  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
    logic [63:0] corr;
  } mul1_t;

  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi0;
    logic [1:0]  mid_c;
    logic [63:0] corr;
  } mul2_t;

  stg_t  pipe_q [0:fpa_pkg::STEPS];
  stg_t  pipe_d [0:fpa_pkg::STEPS];
  mul1_t mul1_q, mul1_d;
  mul2_t mul2_q, mul2_d;
  fpa_pkg::out_t out_q, out_d;
  logic  out_valid_q;
  logic  en;

  logic [63:0]  ua, ub;
  logic [63:0]  hi_full;
  logic [127:0] prod;
  logic [63:0]  mres;
  logic [33:0]  mid;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ua = in_data_i.a;
  assign ub = in_data_i.b;

  // multiply, stage 1: partial products and sign correction
  always_comb begin
    mul1_d.ll   = {32'b0, ua[31:0]} * {32'b0, ub[31:0]};
    mul1_d.lh   = {32'b0, ua[31:0]} * {32'b0, ub[63:32]};
    mul1_d.hl   = {32'b0, ua[63:32]} * {32'b0, ub[31:0]};
    mul1_d.hh   = {32'b0, ua[63:32]} * {32'b0, ub[63:32]};
    mul1_d.corr = (ua[63] ? ub : 64'd0) + (ub[63] ? ua : 64'd0);
  end

  // multiply, stage 2: column sums
  always_comb begin
    mid = {2'b0, mul1_q.ll[63:32]} + {2'b0, mul1_q.lh[31:0]} + {2'b0, mul1_q.hl[31:0]};
    mul2_d.lo    = {mid[31:0], mul1_q.ll[31:0]};
    mul2_d.hi0   = mul1_q.hh + {32'b0, mul1_q.lh[63:32]} + {32'b0, mul1_q.hl[63:32]};
    mul2_d.mid_c = mid[33:32];
    mul2_d.corr  = mul1_q.corr;
  end

  // multiply, stage 3: high word and Q shift
  assign hi_full = mul2_q.hi0 + {62'b0, mul2_q.mid_c} - mul2_q.corr;
  assign prod    = {hi_full, mul2_q.lo};
  assign mres    = prod[fpa_pkg::FRAC_BITS +: 64];

  // entry stage: operand magnitudes, simple ops, zero divisor check;
  // divider stages: one restoring step each
  always_comb begin
    logic [64:0] tr;
    logic        ge;
    pipe_d[0]       = '0;
    pipe_d[0].valid = in_valid_i;
    pipe_d[0].op    = in_data_i.op;
    pipe_d[0].n     = ua[63] ? (64'd0 - ua) : ua;
    pipe_d[0].d     = ub[63] ? (64'd0 - ub) : ub;
    pipe_d[0].neg_q = ua[63] ^ ub[63];
    pipe_d[0].neg_r = ua[63];
    pipe_d[0].dz    = (ub == 64'd0) &&
                      (in_data_i.op == fpa_pkg::OP_DIV || in_data_i.op == fpa_pkg::OP_MOD);
    unique case (in_data_i.op)
      fpa_pkg::OP_ADD:      pipe_d[0].res = ua + ub;
      fpa_pkg::OP_SUB:      pipe_d[0].res = ua - ub;
      fpa_pkg::OP_NEG:      pipe_d[0].res = 64'd0 - ua;
      fpa_pkg::OP_FROM_INT: pipe_d[0].res = ua << fpa_pkg::FRAC_BITS;
      default:              pipe_d[0].res = 64'd0;
    endcase
    for (int k = 1; k <= fpa_pkg::STEPS; k++) begin
      tr = {pipe_q[k-1].rem, pipe_q[k-1].n[63]};
      ge = tr >= {1'b0, pipe_q[k-1].d};
      pipe_d[k]     = pipe_q[k-1];
      pipe_d[k].rem = ge ? 64'(tr - {1'b0, pipe_q[k-1].d}) : tr[63:0];
      pipe_d[k].quo = {pipe_q[k-1].quo[62:0], ge};
      pipe_d[k].n   = {pipe_q[k-1].n[62:0], 1'b0};
      if (k == fpa_pkg::MOD_STEP) begin
        pipe_d[k].modr = pipe_d[k].rem;
      end
      if (k == fpa_pkg::MUL_STEP && pipe_q[k-1].op == fpa_pkg::OP_MUL) begin
        pipe_d[k].res = mres;
      end
    end
  end

  // output select with sign fix-up
  always_comb begin
    stg_t l;
    l = pipe_q[fpa_pkg::STEPS];
    out_d.divide_by_zero = l.dz;
    if (l.dz) begin
      out_d.result = '0;
    end else if (l.op == fpa_pkg::OP_DIV) begin
      out_d.result = l.neg_q ? (64'd0 - l.quo) : l.quo;
    end else if (l.op == fpa_pkg::OP_MOD) begin
      out_d.result = l.neg_r ? (64'd0 - l.modr) : l.modr;
    end else begin
      out_d.result = l.res;
    end
  end

  // pipeline registers; the whole pipe advances together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
      mul1_q      <= '0;
      mul2_q      <= '0;
      for (int k = 0; k <= fpa_pkg::STEPS; k++) begin
        pipe_q[k] <= '0;
      end
    end else if (en) begin
      out_valid_q <= pipe_q[fpa_pkg::STEPS].valid;
      out_q       <= out_d;
      mul1_q      <= mul1_d;
      mul2_q      <= mul2_d;
      for (int k = 0; k <= fpa_pkg::STEPS; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

endmodule

[hdl/fpa_checker.sv]
module fpa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input fpa_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input fpa_pkg::out_t out_data_o
);

  // a stalled input transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input stalls exactly when a waiting result is held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output backpressure");

  // zero divisor forces a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.divide_by_zero |-> out_data_o.result == 64'sd0)
    else $error("divide by zero with nonzero result");

  // pipe comes out of reset empty
  assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result shown right after reset");

endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (.*);

[dv/fixed_point_alu_core_tb.sv]
`timescale 1ns / 1ps

module fixed_point_alu_core_tb;

  localparam int unsigned LATENCY   = 65 + fpa_pkg::FRAC_BITS;
  localparam int unsigned WDOG_MAX  = 20000;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  fpa_pkg::in_t   in_data_i;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  fpa_pkg::out_t  out_data_o;

  fixed_point_alu_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  fpa_pkg::out_t pending_results[$];
  int unsigned num_errors      = 0;
  int unsigned num_sent;
  int unsigned num_checked     = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_cycles = 0;
  logic        hold_off_go;
  int unsigned quiet_cycles    = 0;
  int unsigned op_count[8];
  int unsigned dz_count        = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // 64-bit magnitude helper
  function automatic logic [63:0] magnitude(logic [63:0] v);
    magnitude = v[63] ? (64'd0 - v) : v;
  endfunction

  // expected result of one operation
  function automatic fpa_pkg::out_t alu_predict(fpa_pkg::in_t t);
    fpa_pkg::out_t       r;
    logic signed [127:0] prod;
    logic [127:0]        num;
    logic [127:0]        quo;
    logic [63:0]         rem;
    r.result = '0;
    r.divide_by_zero = 1'b0;
    case (t.op)
      fpa_pkg::OP_ADD: r.result = t.a + t.b;
      fpa_pkg::OP_SUB: r.result = t.a - t.b;
      fpa_pkg::OP_MUL: begin
        prod = 128'(t.a) * 128'(t.b);
        prod = prod >>> fpa_pkg::FRAC_BITS;
        r.result = prod[63:0];
      end
      fpa_pkg::OP_DIV: begin
        if (t.b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          num = {64'd0, magnitude(t.a)} << fpa_pkg::FRAC_BITS;
          quo = num / {64'd0, magnitude(t.b)};
          r.result = (t.a[63] ^ t.b[63]) ? (64'd0 - quo[63:0]) : quo[63:0];
        end
      end
      fpa_pkg::OP_MOD: begin
        if (t.b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          rem = magnitude(t.a) % magnitude(t.b);
          r.result = t.a[63] ? (64'd0 - rem) : rem;
        end
      end
      fpa_pkg::OP_NEG:      r.result = 64'd0 - t.a;
      fpa_pkg::OP_FROM_INT: r.result = t.a << fpa_pkg::FRAC_BITS;
      default:              r.result = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    num_errors++;
    $display("MISMATCH %s: got %h expected %h (result #%0d)", what, got, want, num_checked);
  endtask

  // send one transaction, honoring the sender idle rate
  task automatic send_op(logic [2:0] op, logic [63:0] a, logic [63:0] b);
    fpa_pkg::in_t t;
    t.op = op;
    t.a  = a;
    t.b  = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(alu_predict(t));
    op_count[op]++;
    num_sent++;
  endtask

  // operand with a bias toward edge values
  function automatic logic [63:0] rand_operand();
    case ($urandom_range(9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'(int'($urandom_range(4)) - 2);
      3: return 64'($urandom) << fpa_pkg::FRAC_BITS;
      4: return {{32{1'b1}}, $urandom};
      5: return 64'(signed'($urandom));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // receiver stall generation
  always @(posedge clk_i) begin
    if (hold_off_go) begin
      hold_off_cycles <= 3 * LATENCY;
      out_stall_i <= 1'b1;
    end else if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    fpa_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      num_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_data_o.result, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.result !== want.result)
          report_mismatch("result", out_data_o.result, want.result);
        if (out_data_o.divide_by_zero !== want.divide_by_zero)
          report_mismatch("divide_by_zero", 64'(out_data_o.divide_by_zero),
                          64'(want.divide_by_zero));
        if (want.divide_by_zero) dz_count++;
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("Watchdog expired with %0d results outstanding", pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // edge operands for every op, including zero divisor and min / -1
  task automatic test_directed();
    logic [63:0] mn;
    logic [63:0] mx;
    mn = 64'h8000_0000_0000_0000;
    mx = 64'h7fff_ffff_ffff_ffff;
    send_op(fpa_pkg::OP_ADD, mx, 64'd1);
    send_op(fpa_pkg::OP_ADD, mn, mn);
    send_op(fpa_pkg::OP_SUB, mn, 64'd1);
    send_op(fpa_pkg::OP_SUB, 64'd0, mn);
    send_op(fpa_pkg::OP_MUL, mx, mx);
    send_op(fpa_pkg::OP_MUL, mn, mn);
    send_op(fpa_pkg::OP_MUL, mn, -64'sd1);
    send_op(fpa_pkg::OP_MUL, 64'h0001_8000, -64'sh0002_0000);
    send_op(fpa_pkg::OP_DIV, 64'h0003_0000, 64'd0);
    send_op(fpa_pkg::OP_DIV, mn, -64'sd1);
    send_op(fpa_pkg::OP_DIV, mx, 64'd1);
    send_op(fpa_pkg::OP_DIV, -64'sh0007_0000, 64'h0002_0000);
    send_op(fpa_pkg::OP_DIV, mn, mx);
    send_op(fpa_pkg::OP_MOD, mx, 64'd0);
    send_op(fpa_pkg::OP_MOD, mn, -64'sd1);
    send_op(fpa_pkg::OP_MOD, -64'sd7, 64'sd3);
    send_op(fpa_pkg::OP_MOD, 64'sd7, -64'sd3);
    send_op(fpa_pkg::OP_MOD, mn, mx);
    send_op(fpa_pkg::OP_NEG, mn, mx);
    send_op(fpa_pkg::OP_NEG, mx, 64'd0);
    send_op(fpa_pkg::OP_FROM_INT, mx, mn);
    send_op(fpa_pkg::OP_FROM_INT, -64'sd1, 64'd0);
    send_op(fpa_pkg::OP_UNUSED, mx, mn);
    send_op(fpa_pkg::OP_UNUSED, 64'd0, 64'd0);
  endtask

  task automatic test_random(int unsigned n);
    logic [63:0] b;
    repeat (n) begin
      b = rand_operand();
      if ($urandom_range(19) == 0) b = '0;
      send_op(3'($urandom_range(7)), rand_operand(), b);
    end
  endtask

  // long output hold-off while items keep coming: pipe must fill and stall
  task automatic test_backpressure();
    in_valid_i  <= 1'b0;
    hold_off_go <= 1'b1;
    @(posedge clk_i);
    hold_off_go <= 1'b0;
    test_random(2 * LATENCY);
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    hold_off_go     = 1'b0;
    num_sent        = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    foreach (op_count[i]) op_count[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(400);
    send_idle_pct = 63;
    test_random(350);
    send_idle_pct  = 0;
    recv_stall_pct = 63;
    test_random(350);
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    test_random(350);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_backpressure();
    wait_drained();

    $display("Sent %0d operations, checked %0d results, %0d with zero divisor",
             num_sent, num_checked, dz_count);
    $display("Per op: add %0d sub %0d mul %0d div %0d mod %0d neg %0d int %0d unused %0d",
             op_count[0], op_count[1], op_count[2], op_count[3],
             op_count[4], op_count[5], op_count[6], op_count[7]);
    if (num_errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
